// ----- sv/sgat_pkg.sv -----
// Shared types, widths and codes for the staggered-grid advection term core.
package sgat_pkg;

  // Fixed word widths of the stencil and result fields
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LIMIT_W     = 31;
  localparam int unsigned SCHEME_W    = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Pipeline depth: average, prep, product, partials, shift, cap, sum
  localparam int unsigned NUM_STAGES  = 7;

  // Product widths: |w| * |d| fits 64 bits, times inv gives 96 bits
  localparam int unsigned PROD_W      = 2 * DATA_W;
  localparam int unsigned FULL_W      = 3 * DATA_W;

  // Axis term magnitude is clamped to 2^CAP_BIT
  localparam int unsigned CAP_BIT     = 61;
  localparam int unsigned MAG_W       = CAP_BIT + 1;
  localparam int unsigned TERM_W      = MAG_W + 1;
  localparam int unsigned SUM_W       = TERM_W + 1;
  localparam logic [MAG_W-1:0] TERM_CAP = {1'b1, {CAP_BIT{1'b0}}};

  // Reset value of the reciprocal spacings (1.0 in Q16.16)
  localparam logic [DATA_W-1:0] INV_RESET = 32'h0001_0000;

  // Difference scheme codes; the unused code behaves as central
  typedef enum logic [SCHEME_W-1:0] {
    SCHEME_CENTRAL = 2'd0,
    SCHEME_UPWIND  = 2'd1,
    SCHEME_HYBRID  = 2'd2
  } scheme_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCHEME  = 3'd0,
    CFG_INV_DX  = 3'd1,
    CFG_INV_DY  = 3'd2,
    CFG_LIMIT_X = 3'd3,
    CFG_LIMIT_Y = 3'd4
  } cfg_idx_t;

  // Per-axis operands after scheme selection
  typedef struct packed {
    logic [DATA_W-1:0] mag_w;
    logic [DATA_W-1:0] mag_d;
    logic              central;
    logic              neg;
  } axis_prep_t;

endpackage

// ----- sv/sgat_front.sv -----
// Front stages: transverse average, velocity routing and per-axis difference selection.
module sgat_front (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  logic                                in_op,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_center_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_west_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_east_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_south_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_north_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_0,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_1,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_2,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_3,
  input  logic [sgat_pkg::SCHEME_W-1:0]       scheme,
  input  logic [sgat_pkg::LIMIT_W-1:0]        limit_x,
  input  logic [sgat_pkg::LIMIT_W-1:0]        limit_y,
  output sgat_pkg::axis_prep_t                axis_x,
  output sgat_pkg::axis_prep_t                axis_y
);

  localparam int unsigned W   = sgat_pkg::DATA_W;
  localparam int unsigned SW  = W + 2;

  // Pick the scheme, form the difference and split into magnitudes and sign
  function automatic sgat_pkg::axis_prep_t prep(
    input logic signed [W-1:0]                 w,
    input logic signed [W-1:0]                 c,
    input logic signed [W-1:0]                 m,
    input logic signed [W-1:0]                 p,
    input logic [sgat_pkg::LIMIT_W-1:0]        limit,
    input logic [sgat_pkg::SCHEME_W-1:0]       sch
  );
    sgat_pkg::axis_prep_t r;
    logic [W-1:0]        mw;
    logic                central;
    logic signed [W:0]   ce;
    logic signed [W:0]   me;
    logic signed [W:0]   pe;
    logic signed [W:0]   diff;
    logic signed [W:0]   ndiff;
    mw = w[W-1] ? (~w + 1'b1) : w;
    unique case (sch)
      sgat_pkg::SCHEME_UPWIND: central = 1'b0;
      sgat_pkg::SCHEME_HYBRID: central = (mw < {1'b0, limit});
      default:                 central = 1'b1;
    endcase
    ce = c;
    me = m;
    pe = p;
    if (central) begin
      diff = pe - me;
    end else if (!w[W-1] && (w != '0)) begin
      diff = ce - me;
    end else begin
      diff = pe - ce;
    end
    ndiff     = -diff;
    r.mag_w   = mw;
    r.mag_d   = diff[W] ? ndiff[W-1:0] : diff[W-1:0];
    r.central = central;
    r.neg     = w[W-1] != diff[W];
    return r;
  endfunction

  // Stage 0: stencil capture and floor average of the cross samples
  logic signed [SW-1:0] x0, x1, x2, x3, cross_sum;
  logic                 op_r;
  logic signed [W-1:0]  c_r, west_r, east_r, south_r, north_r, avg_r;

  assign x0 = in_cross_0;
  assign x1 = in_cross_1;
  assign x2 = in_cross_2;
  assign x3 = in_cross_3;
  assign cross_sum = x0 + x1 + x2 + x3;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op_r    <= in_op;
      c_r     <= in_center_value;
      west_r  <= in_west_value;
      east_r  <= in_east_value;
      south_r <= in_south_value;
      north_r <= in_north_value;
      avg_r   <= cross_sum[SW-1:2];
    end
  end

  // Stage 1: route velocities to axes and select differences
  logic signed [W-1:0]  wx, wy;
  sgat_pkg::axis_prep_t axis_x_r, axis_y_r;

  assign wx = op_r ? avg_r : c_r;
  assign wy = op_r ? c_r : avg_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      axis_x_r <= prep(wx, c_r, west_r, east_r, limit_x, scheme);
      axis_y_r <= prep(wy, c_r, south_r, north_r, limit_y, scheme);
    end
  end

  assign axis_x = axis_x_r;
  assign axis_y = axis_y_r;

endmodule

// ----- sv/sgat_axis.sv -----
// Axis datapath: velocity times difference times reciprocal spacing, scaled and clamped.
module sgat_axis #(
  parameter int unsigned FRAC_BITS = sgat_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic [3:0]                           en,
  input  sgat_pkg::axis_prep_t                 prep,
  input  logic [sgat_pkg::DATA_W-1:0]          inv,
  output logic signed [sgat_pkg::TERM_W-1:0]   term
);

  localparam int unsigned W       = sgat_pkg::DATA_W;
  localparam int unsigned PW      = sgat_pkg::PROD_W;
  localparam int unsigned FW      = sgat_pkg::FULL_W;
  localparam int unsigned MW      = sgat_pkg::MAG_W;
  localparam int unsigned TW      = sgat_pkg::TERM_W;
  localparam int unsigned SHIFT_U = 2 * FRAC_BITS;
  localparam int unsigned SHIFT_C = 2 * FRAC_BITS + 1;

  // Stage 2: |w| * |d|
  logic [PW-1:0] prod_r;
  logic          central_2_r, neg_2_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r      <= prep.mag_w * prep.mag_d;
      central_2_r <= prep.central;
      neg_2_r     <= prep.neg;
    end
  end

  // Stage 3: split the 64x32 multiply into two 32x32 partial products
  logic [PW-1:0] part_lo_r, part_hi_r;
  logic          central_3_r, neg_3_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      part_lo_r   <= prod_r[W-1:0] * inv;
      part_hi_r   <= prod_r[PW-1:W] * inv;
      central_3_r <= central_2_r;
      neg_3_r     <= neg_2_r;
    end
  end

  // Stage 4: combine partials, drop fraction bits, flag overflow above the cap range
  logic [FW-1:0] full, shifted;
  logic [MW-1:0] mag_low_r;
  logic          mag_over_r, neg_4_r;

  assign full    = {part_hi_r, {W{1'b0}}} + {{W{1'b0}}, part_lo_r};
  assign shifted = central_3_r ? (full >> SHIFT_C) : (full >> SHIFT_U);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mag_low_r  <= shifted[MW-1:0];
      mag_over_r <= |shifted[FW-1:MW];
      neg_4_r    <= neg_3_r;
    end
  end

  // Stage 5: clamp to the cap and apply the sign
  logic          over;
  logic [MW-1:0] mag;
  logic [TW-1:0] mag_ext;
  logic signed [TW-1:0] term_r;

  assign over    = mag_over_r || (mag_low_r[MW-1] && (|mag_low_r[MW-2:0]));
  assign mag     = over ? sgat_pkg::TERM_CAP : mag_low_r;
  assign mag_ext = {1'b0, mag};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      term_r <= neg_4_r ? signed'(~mag_ext + 1'b1) : signed'(mag_ext);
    end
  end

  assign term = term_r;

endmodule

// ----- sv/sgat_out.sv -----
// Output stage: add both axis terms and saturate to 32 bits.
module sgat_out (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [sgat_pkg::TERM_W-1:0]  term_x,
  input  logic signed [sgat_pkg::TERM_W-1:0]  term_y,
  output logic signed [sgat_pkg::DATA_W-1:0]  advection_term,
  output logic                                saturated
);

  localparam int unsigned SW = sgat_pkg::SUM_W;
  localparam int unsigned W  = sgat_pkg::DATA_W;
  localparam logic signed [SW-1:0] SUM_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  OUT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  OUT_MIN = {1'b1, {(W-1){1'b0}}};

  logic signed [SW-1:0] tx, ty, sum;
  logic                 hi, lo;
  logic signed [W-1:0]  term_r;
  logic                 sat_r;

  assign tx  = term_x;
  assign ty  = term_y;
  assign sum = tx + ty;
  assign hi  = sum > SUM_MAX;
  assign lo  = sum < SUM_MIN;

  // Register the clipped sum
  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= hi ? OUT_MAX : (lo ? OUT_MIN : sum[W-1:0]);
      sat_r  <= hi || lo;
    end
  end

  assign advection_term = term_r;
  assign saturated      = sat_r;

endmodule

// ----- sv/sgat_ctrl.sv -----
// Pipeline control: per-stage valid bits and load enables with backpressure.
module sgat_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             out_ready,
  output logic [sgat_pkg::NUM_STAGES-1:0]  en,
  output logic                             in_ready,
  output logic                             out_valid
);

  localparam int unsigned N = sgat_pkg::NUM_STAGES;

  logic [N-1:0] v_r, v_nxt;

  // A stage loads when it is empty or its contents move on
  assign en[N-1] = !v_r[N-1] || out_ready;

  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  // Advance valid bits with the data
  assign v_nxt[0] = en[0] ? in_valid : v_r[0];

  for (genvar k = 1; k < N; k++) begin : g_vld
    assign v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[N-1];

endmodule

// ----- sv/staggered_grid_advection_term_core.sv -----
// Top level of the staggered-grid advection term core: registers, pipeline and datapath.
//
//   channel  direction  handshake             payload
//   in_      request in in_valid / in_ready    op, center/west/east/south/north, cross_0..3
//   out_     result out out_valid / out_ready  advection_term, saturated
//   cfg_     write in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Seven register stages; out_valid rises once an accepted request has passed through all of them.
// One request per cycle is sustained while the out_ port takes every result.
// Reset (rst_n low, synchronous) empties the pipeline and restores register defaults.
// A stalled out_ port holds every stage that is full; empty stages still fill.
// cfg_ready is always high.
module staggered_grid_advection_term_core #(
  parameter int unsigned FRAC_BITS = sgat_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_center_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_west_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_east_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_south_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_north_value,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_0,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_1,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_2,
  input  logic signed [sgat_pkg::DATA_W-1:0]  in_cross_3,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sgat_pkg::DATA_W-1:0]  out_advection_term,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgat_pkg::DATA_W-1:0]         cfg_data
);

  localparam int unsigned N = sgat_pkg::NUM_STAGES;

  // Configuration registers
  logic [sgat_pkg::SCHEME_W-1:0] scheme_r;
  logic [sgat_pkg::DATA_W-1:0]   inv_dx_r, inv_dy_r;
  logic [sgat_pkg::LIMIT_W-1:0]  limit_x_r, limit_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r  <= sgat_pkg::SCHEME_CENTRAL;
      inv_dx_r  <= sgat_pkg::INV_RESET;
      inv_dy_r  <= sgat_pkg::INV_RESET;
      limit_x_r <= '0;
      limit_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sgat_pkg::CFG_SCHEME:  scheme_r  <= cfg_data[sgat_pkg::SCHEME_W-1:0];
        sgat_pkg::CFG_INV_DX:  inv_dx_r  <= cfg_data;
        sgat_pkg::CFG_INV_DY:  inv_dy_r  <= cfg_data;
        sgat_pkg::CFG_LIMIT_X: limit_x_r <= cfg_data[sgat_pkg::LIMIT_W-1:0];
        sgat_pkg::CFG_LIMIT_Y: limit_y_r <= cfg_data[sgat_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables and valid bits
  logic [N-1:0] en;

  sgat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .en        (en),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // Stages 0-1
  sgat_pkg::axis_prep_t axis_x, axis_y;

  sgat_front u_front (
    .clk             (clk),
    .en              (en[1:0]),
    .in_op           (in_op),
    .in_center_value (in_center_value),
    .in_west_value   (in_west_value),
    .in_east_value   (in_east_value),
    .in_south_value  (in_south_value),
    .in_north_value  (in_north_value),
    .in_cross_0      (in_cross_0),
    .in_cross_1      (in_cross_1),
    .in_cross_2      (in_cross_2),
    .in_cross_3      (in_cross_3),
    .scheme          (scheme_r),
    .limit_x         (limit_x_r),
    .limit_y         (limit_y_r),
    .axis_x          (axis_x),
    .axis_y          (axis_y)
  );

  // Stages 2-5, one lane per axis
  logic signed [sgat_pkg::TERM_W-1:0] term_x, term_y;

  sgat_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk  (clk),
    .en   (en[5:2]),
    .prep (axis_x),
    .inv  (inv_dx_r),
    .term (term_x)
  );

  sgat_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk  (clk),
    .en   (en[5:2]),
    .prep (axis_y),
    .inv  (inv_dy_r),
    .term (term_y)
  );

  // Stage 6
  sgat_out u_out (
    .clk            (clk),
    .en             (en[N-1]),
    .term_x         (term_x),
    .term_y         (term_y),
    .advection_term (out_advection_term),
    .saturated      (out_saturated)
  );

endmodule

// ----- sv/sgat_checker.sv -----
// Port-level checks for the advection term core, bound to the top level.
module sgat_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [sgat_pkg::DATA_W-1:0]  out_advection_term,
  input logic                                out_saturated,
  input logic                                cfg_ready
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_advection_term)
      && $stable(out_saturated))
    else $error("stalled result changed");

  // A clipped result sits at one of the range limits
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_advection_term == 32'sh7fff_ffff) || (out_advection_term == 32'sh8000_0000))
    else $error("saturated flag without clipped value");

  // Input backs up only behind a stalled output
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Register writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind staggered_grid_advection_term_core sgat_checker u_sgat_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_advection_term (out_advection_term),
  .out_saturated      (out_saturated),
  .cfg_ready          (cfg_ready)
);
